// ===== sv/mesh_edge_extraction_core_defines.svh =====
// Assertion macros shared by the edge extraction RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef MESH_EDGE_EXTRACTION_CORE_DEFINES_SVH
`define MESH_EDGE_EXTRACTION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define MEE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mee assertion failed");
// next-cycle implication, disabled in reset
`define MEE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mee assertion failed");
`else
`define MEE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MEE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/mee_pkg.sv =====
// Package for the mesh edge extraction core: widths, constants and the
// request/response structs between the face sequencer and the table scanner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mee_pkg;

   localparam int VIDX_W       = 12;
   localparam int SLOT_W       = 10;
   localparam int MAX_EDGES    = 1024;
   localparam int CNT_W        = 11;
   localparam int KEY_W        = 2 * VIDX_W;
   localparam int CFG_W        = 3;
   localparam int FACE_CORNERS = 4;
   localparam int CORNER_IDX_W = 2;
   localparam int REQ_TDATA_W  = 56;
   localparam int RSP_TDATA_W  = 40;
   localparam int RSP_FIELDS_W = 2 * VIDX_W + SLOT_W + 2;

   localparam logic [CFG_W-1:0] VPF_RESET = 3'd3;
   localparam logic [CFG_W-1:0] VPF_QUAD  = 3'd4;

   localparam logic [CORNER_IDX_W-1:0] LAST_IDX_TRI  = 2'd2;
   localparam logic [CORNER_IDX_W-1:0] LAST_IDX_QUAD = 2'd3;

   typedef struct packed {
      logic              start;
      logic              clear;
      logic [VIDX_W-1:0] hi;
      logic [VIDX_W-1:0] lo;
   } scan_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] slot;
      logic              is_new;
      logic              full;
   } scan_rsp_type;

endpackage
`default_nettype wire

// ===== sv/mee_store.sv =====
// Edge table memory: one write port, one read port with registered data.
// Depends on mee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mee_store (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [mee_pkg::SLOT_W-1:0] wr_addr,
   input  wire logic [mee_pkg::KEY_W-1:0]  wr_data,
   input  wire logic                       rd_en,
   input  wire logic [mee_pkg::SLOT_W-1:0] rd_addr,
   output logic      [mee_pkg::KEY_W-1:0]  rd_data
);
   import mee_pkg::*;

   logic [KEY_W-1:0] store_ff [MAX_EDGES];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/mee_scan.sv =====
// Table scanner: holds the edge count, walks the stored edges one per cycle
// through a single key comparator and appends a missing edge while room is left.
// Depends on mee_pkg, mee_store and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_edge_extraction_core_defines.svh"
module mee_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mee_pkg::scan_req_type scan_req,
   output mee_pkg::scan_rsp_type      scan_rsp
);
   import mee_pkg::*;

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;

   logic              hit, miss, room, issue, wr_en;
   logic [KEY_W-1:0]  rd_data;

   mee_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[SLOT_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   // compare the entry read last cycle; miss once nothing is in flight
   assign hit   = (state_ff == S_SCAN) && cmp_vld_ff && (rd_data == key_ff);
   assign miss  = (state_ff == S_SCAN) && !cmp_vld_ff && (scan_idx_ff == count_ff);
   assign room  = count_ff < CNT_W'(MAX_EDGES);
   assign issue = (state_ff == S_SCAN) && !hit && (scan_idx_ff < count_ff);
   assign wr_en = miss && room;

   always_comb begin
      scan_rsp.done   = hit || miss;
      scan_rsp.is_new = !hit;
      scan_rsp.full   = miss && !room;
      if (hit) begin
         scan_rsp.slot = cmp_idx_ff;
      end else if (room) begin
         scan_rsp.slot = count_ff[SLOT_W-1:0];
      end else begin
         scan_rsp.slot = '0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (scan_req.start) begin
               key_in      = {scan_req.hi, scan_req.lo};
               scan_idx_in = '0;
               state_in    = S_SCAN;
               if (scan_req.clear) begin
                  count_in = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[SLOT_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            if (hit || miss) begin
               state_in = S_IDLE;
            end
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      key_ff      <= key_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
   end

   `MEE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_EDGES))
   `MEE_ASSERT_IMPL(a_write_room, clock, reset, wr_en, count_ff < CNT_W'(MAX_EDGES))
   `MEE_ASSERT_IMPL(a_cmp_in_range, clock, reset, cmp_vld_ff,
                    CNT_W'(cmp_idx_ff) < count_ff)
   `MEE_ASSERT_NEXT(a_done_pulse, clock, reset, scan_rsp.done, !scan_rsp.done)

endmodule
`default_nettype wire

// ===== sv/mesh_edge_extraction_core.sv =====
// Top level of the mesh edge extraction core: face capture, corner count
// register, per-edge sequencing and the result register.
// Depends on mee_pkg, mee_scan and the assertion macro header.
//
//   port group   dir   handshake              payload
//   req_*        in    req_tvalid/req_tready  req_tdata: one face
//   rsp_*        out   rsp_tvalid/rsp_tready  rsp_tdata, rsp_tlast: one edge
//   csr_*        in    csr_valid/csr_ready    csr_data: verts_per_face
//
// A face is accepted, then each edge passes a start state, a scan of the
// stored edges and a result state that waits for rsp_tready; the table
// scan reads one stored edge per cycle through the single memory read
// port and one key comparator.
// Reset clears the edge count and control state only; no memory sweep.
// A stalled result holds the core; req_tready is high only between faces.
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_edge_extraction_core_defines.svh"
module mesh_edge_extraction_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // clear_table, corner0, corner1, corner2, corner3 (lowest bit up)
   input  wire logic [mee_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // edge_low, edge_high, edge_slot, is_new, table_full (lowest bit up)
   output logic      [mee_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mee_pkg::CFG_W-1:0]       csr_data
);
   import mee_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_EDGE, T_WAIT, T_SEND} state_type;

   state_type               state_ff;
   logic [CFG_W-1:0]        vpf_ff;
   logic [VIDX_W-1:0]       corner_ff [FACE_CORNERS];
   logic                    clear_ff;
   logic [CORNER_IDX_W-1:0] edge_idx_ff;
   logic [CORNER_IDX_W-1:0] last_idx_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic                    rsp_last_ff;
   logic                    rsp_vld_ff;

   logic [CORNER_IDX_W-1:0] b_idx;
   logic [VIDX_W-1:0]       end_a, end_b, edge_lo, edge_hi;
   logic                    is_last;
   scan_req_type            scan_req;
   scan_rsp_type            scan_rsp;

   assign req_tready = (state_ff == T_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // closing edge wraps back to corner0
   assign is_last = (edge_idx_ff == last_idx_ff);
   assign b_idx   = is_last ? '0 : edge_idx_ff + CORNER_IDX_W'(1);
   assign end_a   = corner_ff[edge_idx_ff];
   assign end_b   = corner_ff[b_idx];
   assign edge_lo = (end_a < end_b) ? end_a : end_b;
   assign edge_hi = (end_a < end_b) ? end_b : end_a;

   always_comb begin
      scan_req.start = (state_ff == T_EDGE);
      scan_req.clear = clear_ff && (edge_idx_ff == '0);
      scan_req.hi    = edge_hi;
      scan_req.lo    = edge_lo;
   end

   mee_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         vpf_ff     <= VPF_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            vpf_ff <= csr_data;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (req_tvalid) begin
                  clear_ff     <= req_tdata[0];
                  corner_ff[0] <= req_tdata[12:1];
                  corner_ff[1] <= req_tdata[24:13];
                  corner_ff[2] <= req_tdata[36:25];
                  corner_ff[3] <= req_tdata[48:37];
                  edge_idx_ff  <= '0;
                  last_idx_ff  <= (vpf_ff >= VPF_QUAD) ? LAST_IDX_QUAD : LAST_IDX_TRI;
                  state_ff     <= T_EDGE;
               end
            end
            T_EDGE: begin
               state_ff <= T_WAIT;
            end
            T_WAIT: begin
               if (scan_rsp.done) begin
                  rsp_data_ff <= RSP_TDATA_W'({scan_rsp.full, scan_rsp.is_new,
                                               scan_rsp.slot, edge_hi, edge_lo});
                  rsp_last_ff <= is_last;
                  rsp_vld_ff  <= 1'b1;
                  state_ff    <= T_SEND;
               end
            end
            T_SEND: begin
               // advance to the next edge, or back to idle after the last, once the result is taken
               if (rsp_tready) begin
                  rsp_vld_ff <= 1'b0;
                  if (is_last) begin
                     state_ff <= T_IDLE;
                  end else begin
                     edge_idx_ff <= edge_idx_ff + CORNER_IDX_W'(1);
                     state_ff    <= T_EDGE;
                  end
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   `MEE_ASSERT_IMPL(a_no_req_with_rsp, clock, reset, rsp_tvalid, !req_tready)
   `MEE_ASSERT_IMPL(a_done_in_wait, clock, reset, scan_rsp.done, state_ff == T_WAIT)
   `MEE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule
`default_nettype wire

// ===== test/mesh_edge_extraction_checker.sv =====
`timescale 1ns / 1ps
// Checker for the mesh edge extraction core: watches the request, result and
// CSR channels, predicts every edge result and compares it field by field.
// Depends on mee_pkg only.
module mesh_edge_extraction_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // clear_table, corner0, corner1, corner2, corner3 (lowest bit up)
   input  wire logic [mee_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // edge_low, edge_high, edge_slot, is_new, table_full (lowest bit up)
   input  wire logic [mee_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                            rsp_tlast,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [mee_pkg::CFG_W-1:0]       csr_data,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   edges_checked,
   output int                                   drops_seen
);
   import mee_pkg::*;

   typedef struct packed {
      logic [VIDX_W-1:0] lo;
      logic [VIDX_W-1:0] hi;
      logic [SLOT_W-1:0] slot;
      logic              fresh;
      logic              dropped;
      logic              closing;
   } edge_result_type;

   logic [KEY_W-1:0] edge_table [MAX_EDGES];
   int               edges_stored;
   logic [CFG_W-1:0] face_size_reg;
   edge_result_type  pending_edges [$];

   function automatic int corners_in_use();
      if (face_size_reg < VPF_RESET) return 3;
      if (face_size_reg > VPF_QUAD) return 4;
      return int'(face_size_reg);
   endfunction

   // search from slot 0 up, append on a miss, drop when the table is full
   task automatic record_edge(input logic [VIDX_W-1:0] a, input logic [VIDX_W-1:0] b,
                              input logic closing);
      edge_result_type  r;
      logic [KEY_W-1:0] key;
      int               hit;
      int               j;
      r.lo      = (a < b) ? a : b;
      r.hi      = (a < b) ? b : a;
      r.closing = closing;
      r.dropped = 1'b0;
      key = {r.hi, r.lo};
      hit = -1;
      j   = 0;
      while (hit < 0 && j < edges_stored) begin
         if (edge_table[j] == key) hit = j;
         j++;
      end
      r.fresh = (hit < 0);
      if (hit >= 0) begin
         r.slot = SLOT_W'(hit);
      end else if (edges_stored < MAX_EDGES) begin
         r.slot = SLOT_W'(edges_stored);
         edge_table[edges_stored] = key;
         edges_stored++;
      end else begin
         r.slot    = '0;
         r.dropped = 1'b1;
      end
      pending_edges.insert(pending_edges.size(), r);
   endtask

   task automatic predict_face(input logic [REQ_TDATA_W-1:0] data);
      logic [VIDX_W-1:0] corner [FACE_CORNERS];
      int                n;
      int                k;
      n = corners_in_use();
      if (data[0]) edges_stored = 0;
      for (k = 0; k < FACE_CORNERS; k++) corner[k] = data[1 + k * VIDX_W +: VIDX_W];
      for (k = 0; k < n - 1; k++) record_edge(corner[k], corner[k + 1], 1'b0);
      record_edge(corner[n - 1], corner[0], 1'b1);
   endtask

   task automatic check_field(input string name, input logic [VIDX_W-1:0] want,
                              input logic [VIDX_W-1:0] got);
      if (got !== want) begin
         $display("%0t edge result %s mismatch: expected %0d, actual %0d",
                  $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      edge_result_type want;
      if (reset) begin
         edges_stored  = 0;
         face_size_reg = VPF_RESET;
         mismatches    = 0;
         edges_checked = 0;
         drops_seen    = 0;
         pending_edges.delete();
      end else begin
         if (csr_valid && csr_ready) face_size_reg = csr_data;
         // results first, so a request in the same cycle cannot hide a stray one
         if (rsp_tvalid && rsp_tready) begin
            if (pending_edges.size() == 0) begin
               $display("%0t unexpected edge result: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = pending_edges.pop_front();
               check_field("edge_low", want.lo, rsp_tdata[11:0]);
               check_field("edge_high", want.hi, rsp_tdata[23:12]);
               check_field("edge_slot", VIDX_W'(want.slot), VIDX_W'(rsp_tdata[33:24]));
               check_field("is_new", VIDX_W'(want.fresh), VIDX_W'(rsp_tdata[34]));
               check_field("table_full", VIDX_W'(want.dropped), VIDX_W'(rsp_tdata[35]));
               check_field("padding", '0, VIDX_W'(rsp_tdata[RSP_TDATA_W-1:36]));
               check_field("last_edge", VIDX_W'(want.closing), VIDX_W'(rsp_tlast));
               edges_checked++;
               if (want.dropped) drops_seen++;
            end
         end
         if (req_tvalid && req_tready) predict_face(req_tdata);
      end
      outstanding <= pending_edges.size();
   end

endmodule

// ===== test/mesh_edge_extraction_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for mesh_edge_extraction_core: drives faces and corner count
// writes, throttles the result side and gives the verdict.
// Depends on mee_pkg, the core RTL and mesh_edge_extraction_checker.
module mesh_edge_extraction_core_tb;
   import mee_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_FACES  = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data = '0;
   logic                   hold_go = 1'b0;

   int                     mismatches;
   int                     outstanding;
   int                     edges_checked;
   int                     drops_seen;
   int                     idle_cycles = 0;
   int                     burst_left = 0;
   int                     faces_sent = 0;
   int                     settings_used = 0;
   logic [VIDX_W-1:0]      pool_base;

   mesh_edge_extraction_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mesh_edge_extraction_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .edges_checked (edges_checked),
      .drops_seen    (drops_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: stall patterns of random length; a long hold-off on request
   initial begin : result_sink
      int style;
      int stretch;
      int k;
      forever begin
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(10, 150);
         for (k = 0; k < stretch; k++) begin
            @(posedge clock);
            if (hold_go) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_go <= 1'b0;
            end
            case (style)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= ~rsp_tready;
               end
            endcase
         end
      end
   end

   task automatic send_face(input logic clear, input logic [VIDX_W-1:0] c0,
                            input logic [VIDX_W-1:0] c1, input logic [VIDX_W-1:0] c2,
                            input logic [VIDX_W-1:0] c3, input bit no_gap);
      int gap;
      if (!no_gap && burst_left == 0) begin
         gap        = $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({c3, c2, c1, c0, clear});
      do @(posedge clock); while (!req_tready);
      faces_sent++;
   endtask

   task automatic send_random_face(input logic force_clear, input bit no_gap);
      logic [VIDX_W-1:0] v [FACE_CORNERS];
      int                style;
      int                k;
      style = $urandom_range(0, 9);
      for (k = 0; k < FACE_CORNERS; k++) begin
         if (style <= 6)
            v[k] = pool_base + VIDX_W'($urandom_range(0, 9));
         else if (style == 7)
            v[k] = VIDX_W'($urandom);
         else if (style == 8)
            v[k] = (k == 0 || $urandom_range(0, 1) == 1) ? pool_base : pool_base + 1'b1;
         else
            v[k] = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      send_face(force_clear || ($urandom_range(0, 11) == 0), v[0], v[1], v[2], v[3],
                no_gap);
   endtask

   // hold the sender until every predicted edge has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_face_size(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] phase_sizes [8];
      int               f;
      int               p;
      int               hold_at;
      phase_sizes = '{3'd0, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5, 3'd3, 3'd7};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // triangles at the reset corner count
      send_face(1'b1, 12'd0, 12'd0, 12'd0, 12'hFFF, 1'b0);
      send_face(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 1'b0);
      send_face(1'b0, 12'd0, 12'hFFF, 12'd2048, 12'd1234, 1'b0);
      send_face(1'b0, 12'd2048, 12'hFFF, 12'd0, 12'hABC, 1'b0);
      send_face(1'b0, 12'd1, 12'd2, 12'd1, 12'd7, 1'b0);
      send_face(1'b1, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 1'b0);
      drain_results();

      // quads: repeated and degenerate edges, reversed winding
      write_face_size(VPF_QUAD);
      send_face(1'b1, 12'd5, 12'd9, 12'd5, 12'd9, 1'b0);
      send_face(1'b0, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 1'b0);
      send_face(1'b0, 12'h123, 12'h456, 12'h789, 12'hABC, 1'b0);
      send_face(1'b0, 12'hABC, 12'h789, 12'h456, 12'h123, 1'b0);
      send_face(1'b0, 12'd7, 12'd7, 12'd7, 12'd7, 1'b0);
      drain_results();

      // random meshes over a small vertex pool, one corner count per phase
      for (p = 0; p < 8; p++) begin
         if (p > 0) drain_results();
         write_face_size(phase_sizes[p]);
         pool_base = VIDX_W'($urandom);
         hold_at   = $urandom_range(2, PHASE_FACES - 8);
         for (f = 0; f < PHASE_FACES; f++) begin
            if (f == hold_at) begin
               // stall the result side while faces keep coming
               hold_go <= 1'b1;
               repeat (6) send_random_face(1'b0, 1'b1);
            end
            send_random_face(p == 0 && f == 0, 1'b0);
         end
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d faces over %0d corner count settings, with long result stalls.",
               faces_sent, settings_used);
      $display("Edge results checked: %0d, of them %0d dropped for lack of space.",
               edges_checked, drops_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/mee_pkg.sv
sv/mee_store.sv
sv/mee_scan.sv
sv/mesh_edge_extraction_core.sv
test/mesh_edge_extraction_checker.sv
test/mesh_edge_extraction_core_tb.sv
